// ===== src/ptc_pkg.sv =====
// Shared types, constants and helper functions for the pressure and
// temperature compensation block. No dependencies.
`default_nettype none

package ptc_pkg;

  // Queue between the front (coefficient arithmetic) and back (divider) parts
  localparam int unsigned QUEUE_DEPTH = 4;

  // Width of the dividend and quotient of the pressure division
  localparam int unsigned NUM_W = 64;

  // Compensation constants
  localparam logic [32:0] TF_OFFSET = 33'd128000;
  localparam logic [20:0] P_FULL    = 21'd1048576;
  localparam logic [11:0] NUM_SCALE = 12'd3125;
  localparam logic [63:0] X_BIAS    = 64'h0000_8000_0000_0000;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TF_ZERO  = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_TEMP    = 2'd0;
  localparam logic [1:0] REG_PRESS_A = 2'd1;
  localparam logic [1:0] REG_PRESS_B = 2'd2;
  localparam logic [1:0] REG_PRESS_C = 2'd3;

  typedef struct packed {
    logic [47:0] temp;
    logic [47:0] press_a;
    logic [47:0] press_b;
    logic [47:0] press_c;
  } ptc_coeffs_t;

  // One classified item handed from front to back
  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] tf;
    logic [63:0] num;
    logic [31:0] den;
    logic [1:0]  status;
  } ptc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ptc_queue_stat_t;

  // Low 32-bit slice times a signed 16-bit coefficient, sign-extended to 64
  function automatic logic [63:0] mul_lo16(input logic [31:0] x, input logic [15:0] s);
    logic signed [48:0] p;
    p = $signed({1'b0, x}) * $signed(s);
    return {{15{p[48]}}, p};
  endfunction

  // High 32-bit slice times a signed 16-bit coefficient, low 32 bits only
  function automatic logic [31:0] mul_hi16(input logic [31:0] x, input logic [15:0] s);
    logic signed [48:0] p;
    p = $signed({1'b0, x}) * $signed(s);
    return p[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/ptc_queue.sv =====
// Short register queue between the front and back parts.
// Depends on ptc_pkg.
`default_nettype none

module ptc_queue #(
  parameter int unsigned Depth = ptc_pkg::QUEUE_DEPTH
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  ptc_pkg::ptc_item_t      item_in,
  input  wire                     pop,
  output ptc_pkg::ptc_item_t      head,
  output ptc_pkg::ptc_queue_stat_t stat
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  ptc_pkg::ptc_item_t mem [Depth];
  logic [IdxW-1:0] wr_ptr;
  logic [IdxW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == CntW'(Depth));
  assign stat.empty = (count == '0);

endmodule

`default_nettype wire

// ===== src/ptc_front.sv =====
// Front part: temperature compensation and the pressure dividend/divisor,
// with status classification. Depends on ptc_pkg.
`default_nettype none

module ptc_front (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  [19:0]              temp_sample,
  input  wire  [19:0]              press_sample,
  input  ptc_pkg::ptc_coeffs_t     coeffs,
  input  ptc_pkg::ptc_queue_stat_t qstat,
  output logic                     push,
  output ptc_pkg::ptc_item_t       item
);

  localparam int unsigned Stages = 11;

  logic [Stages-1:0] v;
  logic en;

  logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
  assign t1 = coeffs.temp[15:0];
  assign t2 = coeffs.temp[31:16];
  assign t3 = coeffs.temp[47:32];
  assign p1 = coeffs.press_a[15:0];
  assign p2 = coeffs.press_a[31:16];
  assign p3 = coeffs.press_a[47:32];
  assign p4 = coeffs.press_b[15:0];
  assign p5 = coeffs.press_b[31:16];
  assign p6 = coeffs.press_b[47:32];

  // Hold the whole pipe while the queue cannot take the oldest item
  assign en       = !(v[Stages-1] && qstat.full);
  assign in_stall = !en;
  assign push     = v[Stages-1] && !qstat.full;

  logic [19:0] rt0;
  logic [19:0] rp [8];
  logic [31:0] am1, dd1, a2, bm2;
  logic [31:0] tf [3:10];
  logic [31:0] tc [4:10];
  logic signed [32:0] v1_4;
  logic [63:0] sq5, v1p5_5, v1p2_5, v1p5_6, v1p2_6;
  logic [63:0] sqp6lo6, sqp3lo6;
  logic [31:0] sqp6hi6, sqp3hi6;
  logic [63:0] v2_7, t7, n0_8;
  logic [47:0] xplo8;
  logic [31:0] xphi8, den9, den10;
  logic [43:0] nmlo9;
  logic [31:0] nmhi9;
  logic [63:0] num10;
  logic [1:0]  status10;

  logic [31:0] x32_c, d32_c, am_c, dd_c, bm_c, tcm_c;
  logic signed [31:0] a_c, dsh_c, bsh_c, tc_c;
  logic signed [65:0] sq_c;
  logic signed [48:0] v1p5_c, v1p2_c;
  logic [63:0] sqp3_c, x_c, xs_c, den_c;
  logic signed [63:0] sqp3s_c;
  logic [47:0] xplo_c;
  logic [31:0] xphi_c, nmhi_c;
  logic [43:0] nmlo_c;
  logic [20:0] pf_c;

  always_comb begin
    x32_c   = {15'b0, rt0[19:3]} - {15'b0, t1, 1'b0};
    am_c    = x32_c * {{16{t2[15]}}, t2};
    d32_c   = {16'b0, rt0[19:4]} - {16'b0, t1};
    dd_c    = d32_c * d32_c;
    a_c     = $signed(am1) >>> 11;
    dsh_c   = $signed(dd1) >>> 12;
    bm_c    = dsh_c * {{16{t3[15]}}, t3};
    bsh_c   = $signed(bm2) >>> 14;
    tcm_c   = tf[3] * 32'd5 + 32'd128;
    tc_c    = $signed(tcm_c) >>> 8;
    sq_c    = v1_4 * v1_4;
    v1p5_c  = v1_4 * $signed(p5);
    v1p2_c  = v1_4 * $signed(p2);
    sqp3_c  = sqp3lo6 + {sqp3hi6, 32'b0};
    sqp3s_c = $signed(sqp3_c) >>> 8;
    x_c     = t7 + ptc_pkg::X_BIAS;
    xplo_c  = x_c[31:0] * p1;
    xphi_c  = x_c[63:32] * {16'b0, p1};
    pf_c    = ptc_pkg::P_FULL - {1'b0, rp[7]};
    xs_c    = {16'b0, xplo8} + {xphi8, 32'b0};
    den_c   = $signed(xs_c) >>> 33;
    nmlo_c  = n0_8[31:0] * ptc_pkg::NUM_SCALE;
    nmhi_c  = n0_8[63:32] * {20'b0, ptc_pkg::NUM_SCALE};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[Stages-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt0   <= temp_sample;
      rp[0] <= press_sample;
      for (int k = 1; k < 8; k++) begin
        rp[k] <= rp[k-1];
      end
      am1 <= am_c;
      dd1 <= dd_c;
      a2  <= a_c;
      bm2 <= bm_c;
      tf[3] <= a2 + bsh_c;
      for (int k = 4; k <= 10; k++) begin
        tf[k] <= tf[k-1];
      end
      tc[4] <= tc_c;
      for (int k = 5; k <= 10; k++) begin
        tc[k] <= tc[k-1];
      end
      v1_4    <= {tf[3][31], tf[3]} - ptc_pkg::TF_OFFSET;
      sq5     <= sq_c[63:0];
      v1p5_5  <= {{15{v1p5_c[48]}}, v1p5_c};
      v1p2_5  <= {{15{v1p2_c[48]}}, v1p2_c};
      sqp6lo6 <= ptc_pkg::mul_lo16(sq5[31:0], p6);
      sqp6hi6 <= ptc_pkg::mul_hi16(sq5[63:32], p6);
      sqp3lo6 <= ptc_pkg::mul_lo16(sq5[31:0], p3);
      sqp3hi6 <= ptc_pkg::mul_hi16(sq5[63:32], p3);
      v1p5_6  <= v1p5_5;
      v1p2_6  <= v1p2_5;
      v2_7    <= sqp6lo6 + {sqp6hi6, 32'b0} + (v1p5_6 << 17)
                 + ({{48{p4[15]}}, p4} << 35);
      t7      <= sqp3s_c + (v1p2_6 << 12);
      xplo8   <= xplo_c;
      xphi8   <= xphi_c;
      n0_8    <= {12'b0, pf_c, 31'b0} - v2_7;
      den9    <= den_c[31:0];
      nmlo9   <= nmlo_c;
      nmhi9   <= nmhi_c;
      num10   <= {20'b0, nmlo9} + {nmhi9, 32'b0};
      den10   <= den9;
      if (tf[9] == '0) begin
        status10 <= ptc_pkg::ST_TF_ZERO;
      end else if (den9 == '0) begin
        status10 <= ptc_pkg::ST_DIV_ZERO;
      end else begin
        status10 <= ptc_pkg::ST_OK;
      end
    end
  end

  assign item.tc     = tc[10];
  assign item.tf     = tf[10];
  assign item.num    = num10;
  assign item.den    = den10;
  assign item.status = status10;

endmodule

`default_nettype wire

// ===== src/ptc_back.sv =====
// Back part: pipelined signed division and the final pressure polish.
// Depends on ptc_pkg.
`default_nettype none

module ptc_back (
  input  wire                      clk,
  input  wire                      rst,
  input  ptc_pkg::ptc_queue_stat_t qstat,
  input  ptc_pkg::ptc_item_t       head,
  output logic                     pop,
  input  ptc_pkg::ptc_coeffs_t     coeffs,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic [31:0]              temperature_centi,
  output logic [31:0]              fine_temperature,
  output logic [31:0]              pressure_q24_8,
  output logic [1:0]               status
);

  localparam int unsigned DivBits = ptc_pkg::NUM_W;
  localparam int unsigned Post    = 6;

  logic en;
  assign en  = !(out_valid && out_stall);
  assign pop = en && !qstat.empty;

  logic [15:0] p7, p8, p9;
  assign p7 = coeffs.press_c[15:0];
  assign p8 = coeffs.press_c[31:16];
  assign p9 = coeffs.press_c[47:32];

  // Division pipe: index 0 is the set-up stage, index k the k-th quotient bit
  logic        dv   [DivBits+1];
  logic [63:0] dnq  [DivBits+1];
  logic [31:0] drem [DivBits+1];
  logic [31:0] dad  [DivBits+1];
  logic        dsgn [DivBits+1];
  ptc_pkg::ptc_item_t dside [DivBits+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= !qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dnq[0]   <= head.num[63] ? (64'd0 - head.num) : head.num;
      dad[0]   <= head.den[31] ? (32'd0 - head.den) : head.den;
      drem[0]  <= '0;
      dsgn[0]  <= head.num[63] ^ head.den[31];
      dside[0] <= head;
    end
  end

  for (genvar k = 0; k < DivBits; k++) begin : g_div
    logic [32:0] r2;
    logic [32:0] diff;
    logic        ge;

    always_comb begin
      r2   = {drem[k], dnq[k][63]};
      diff = r2 - {1'b0, dad[k]};
      ge   = (r2 >= {1'b0, dad[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem[k+1]  <= ge ? diff[31:0] : r2[31:0];
        dnq[k+1]   <= {dnq[k][62:0], ge};
        dad[k+1]   <= dad[k];
        dsgn[k+1]  <= dsgn[k];
        dside[k+1] <= dside[k];
      end
    end
  end

  // Post-division stages
  logic [Post-1:0] pv;
  ptc_pkg::ptc_item_t ps [Post-1];
  logic [63:0] p_q [1:5];
  logic [63:0] ll2, w2lo2, qq3, w2x [3:5], w1lo4, w1x5;
  logic [31:0] lh2, w2hi2, w1hi4;

  logic signed [63:0] qv_c, w1s_c, w2s_c, r_c;
  logic [63:0] s_c;
  logic [31:0] res_c;

  always_comb begin
    qv_c  = $signed(p_q[1]) >>> 13;
    w1s_c = $signed(w1x5) >>> 25;
    w2s_c = $signed(w2x[5]) >>> 19;
    s_c   = p_q[5] + w1s_c + w2s_c;
    r_c   = $signed(s_c) >>> 8;
    res_c = r_c[31:0] + {{12{p7[15]}}, p7, 4'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (en) begin
      pv <= {pv[Post-2:0], dv[DivBits]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps[0]  <= dside[DivBits];
      for (int k = 1; k < Post - 1; k++) begin
        ps[k] <= ps[k-1];
      end
      p_q[1] <= dsgn[DivBits] ? (64'd0 - dnq[DivBits]) : dnq[DivBits];
      for (int k = 2; k <= 5; k++) begin
        p_q[k] <= p_q[k-1];
      end
      ll2    <= qv_c[31:0] * qv_c[31:0];
      lh2    <= qv_c[31:0] * qv_c[63:32];
      w2lo2  <= ptc_pkg::mul_lo16(p_q[1][31:0], p8);
      w2hi2  <= ptc_pkg::mul_hi16(p_q[1][63:32], p8);
      qq3    <= ll2 + {lh2[30:0], 1'b0, 32'b0};
      w2x[3] <= w2lo2 + {w2hi2, 32'b0};
      w2x[4] <= w2x[3];
      w2x[5] <= w2x[4];
      w1lo4  <= ptc_pkg::mul_lo16(qq3[31:0], p9);
      w1hi4  <= ptc_pkg::mul_hi16(qq3[63:32], p9);
      w1x5   <= w1lo4 + {w1hi4, 32'b0};
      temperature_centi <= ps[4].tc;
      fine_temperature  <= ps[4].tf;
      status            <= ps[4].status;
      pressure_q24_8    <= (ps[4].status == ptc_pkg::ST_OK) ? res_c : '0;
    end
  end

  assign out_valid = pv[Post-1];

endmodule

`default_nettype wire

// ===== src/pressure_temp_compensation.sv =====
// Top level of the pressure and temperature compensation block: register
// port, front part, queue and back part. Depends on ptc_pkg and all ptc_ modules.
// Takes one pair of raw readings per transfer and returns one result per pair:
// temperature in hundredths of a degree, the fine temperature, pressure in
// unsigned Q24.8 pascals and a status (fine temperature zero or divisor zero
// force the pressure to 0). A new pair is taken every cycle while the output
// side keeps up. Each pair passes the front part, the queue and the back part,
// whose core is the 64-stage restoring divider that yields one quotient bit
// per stage. The front and back stall independently; the queue absorbs short
// output stalls. Coefficients sit in four 48-bit registers at byte addresses
// 0, 8, 16 and 24 and are to be written only while the block holds no items.
`default_nettype none

module pressure_temp_compensation #(
  parameter int unsigned QueueDepth = ptc_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst,
  // APB configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // input channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [19:0] temp_sample,
  input  wire  [19:0] press_sample,
  // output channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] temperature_centi,
  output logic [31:0] fine_temperature,
  output logic [31:0] pressure_q24_8,
  output logic [1:0]  status
);

  ptc_pkg::ptc_coeffs_t     coeffs;
  ptc_pkg::ptc_item_t       q_in;
  ptc_pkg::ptc_item_t       q_head;
  ptc_pkg::ptc_queue_stat_t qstat;
  logic push;
  logic pop;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes: one transfer updates the addressed coefficient word
  always_ff @(posedge clk) begin
    if (rst) begin
      coeffs <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:3])
        ptc_pkg::REG_TEMP:    coeffs.temp    <= pwdata[47:0];
        ptc_pkg::REG_PRESS_A: coeffs.press_a <= pwdata[47:0];
        ptc_pkg::REG_PRESS_B: coeffs.press_b <= pwdata[47:0];
        ptc_pkg::REG_PRESS_C: coeffs.press_c <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed coefficient word, zero-extended
  always_comb begin
    unique case (paddr[4:3])
      ptc_pkg::REG_TEMP:    prdata = {16'b0, coeffs.temp};
      ptc_pkg::REG_PRESS_A: prdata = {16'b0, coeffs.press_a};
      ptc_pkg::REG_PRESS_B: prdata = {16'b0, coeffs.press_b};
      ptc_pkg::REG_PRESS_C: prdata = {16'b0, coeffs.press_c};
      default:              prdata = '0;
    endcase
  end

  // Front: temperature, dividend, divisor and status
  ptc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .temp_sample  (temp_sample),
    .press_sample (press_sample),
    .coeffs       (coeffs),
    .qstat        (qstat),
    .push         (push),
    .item         (q_in)
  );

  // Decouple the two parts
  ptc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item_in (q_in),
    .pop     (pop),
    .head    (q_head),
    .stat    (qstat)
  );

  // Back: division and final pressure
  ptc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .qstat             (qstat),
    .head              (q_head),
    .pop               (pop),
    .coeffs            (coeffs),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .fine_temperature  (fine_temperature),
    .pressure_q24_8    (pressure_q24_8),
    .status            (status)
  );

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("queue overflow");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("queue underflow");

  // An error status always carries zero pressure
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ptc_pkg::ST_OK) |-> pressure_q24_8 == '0)
    else $error("error result with non-zero pressure");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for pressure_temp_compensation: APB coefficient set-up,
// raw reading transfers in, compensated results out, checked by a local predictor.
// Depends on ptc_pkg and the RTL of the block.
`timescale 1ns / 100ps

class comp_scoreboard;
  typedef struct {
    logic [31:0] tc;
    logic [31:0] tf;
    logic [31:0] press;
    logic [1:0]  st;
  } comp_result_t;

  logic [47:0]  coeff [4] = '{default: 48'd0};
  comp_result_t pending [$];
  int           errors;
  int           checked;
  int           st_seen [3];

  function logic [31:0] sxt32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function logic [63:0] sxt64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function logic [63:0] quot64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] an, ad, q;
    an = n[63] ? -n : n;
    ad = d[63] ? -d : d;
    q = an / ad;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  // Compute the expected result for one reading pair and queue it
  function void note_reading(input logic [19:0] rt, input logic [19:0] rp);
    comp_result_t r;
    logic [31:0] t1, t2, t3, a, dd, b, tf;
    logic signed [31:0] s;
    logic signed [63:0] v1, v2, p, q, w1, w2;
    logic [63:0] pc [1:9];
    t1 = {16'd0, coeff[0][15:0]};
    t2 = sxt32(coeff[0][31:16]);
    t3 = sxt32(coeff[0][47:32]);
    s = ({12'd0, rt} >> 3) - (t1 << 1);
    s = s * $signed(t2);
    a = s >>> 11;
    dd = ({12'd0, rt} >> 4) - t1;
    s = dd * dd;
    s = s >>> 12;
    s = s * $signed(t3);
    b = s >>> 14;
    tf = a + b;
    s = tf * 32'd5 + 32'd128;
    r.tc = s >>> 8;
    r.tf = tf;
    r.press = '0;
    r.st = ptc_pkg::ST_OK;
    if (tf == 0) begin
      r.st = ptc_pkg::ST_TF_ZERO;
    end else begin
      pc[1] = {48'd0, coeff[1][15:0]};
      pc[2] = sxt64(coeff[1][31:16]);
      pc[3] = sxt64(coeff[1][47:32]);
      for (int k = 0; k < 3; k++) begin
        pc[4 + k] = sxt64(coeff[2][16*k +: 16]);
        pc[7 + k] = sxt64(coeff[3][16*k +: 16]);
      end
      v1 = {{32{tf[31]}}, tf} - 64'sd128000;
      v2 = v1 * v1 * $signed(pc[6]);
      v2 = v2 + ((v1 * $signed(pc[5])) << 17);
      v2 = v2 + (pc[4] << 35);
      v1 = ((v1 * v1 * $signed(pc[3])) >>> 8) + ((v1 * $signed(pc[2])) << 12);
      v1 = (((64'sd1 << 47) + v1) * $signed(pc[1])) >>> 33;
      if (v1 == 0) begin
        r.st = ptc_pkg::ST_DIV_ZERO;
      end else begin
        p = 64'd1048576 - {44'd0, rp};
        p = quot64(((p << 31) - v2) * 64'd3125, v1);
        q = p >>> 13;
        w1 = ($signed(pc[9]) * q * q) >>> 25;
        w2 = ($signed(pc[8]) * p) >>> 19;
        p = ((p + w1 + w2) >>> 8) + (pc[7] << 4);
        r.press = p[31:0];
      end
    end
    pending.push_back(r);
  endfunction

  function void check_result(input logic [31:0] tc, input logic [31:0] tf,
                             input logic [31:0] press, input logic [1:0] st);
    comp_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result tc=%h tf=%h p=%h st=%0d", $time, tc, tf, press, st);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (st <= 2) st_seen[st]++;
    if (tc !== e.tc) begin
      $display("%0t: temperature_centi expected %h actual %h", $time, e.tc, tc);
      errors++;
    end
    if (tf !== e.tf) begin
      $display("%0t: fine_temperature expected %h actual %h", $time, e.tf, tf);
      errors++;
    end
    if (press !== e.press) begin
      $display("%0t: pressure_q24_8 expected %h actual %h", $time, e.press, press);
      errors++;
    end
    if (st !== e.st) begin
      $display("%0t: status expected %0d actual %0d", $time, e.st, st);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [19:0] temp_sample = '0;
  logic [19:0] press_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] temperature_centi;
  logic [31:0] fine_temperature;
  logic [31:0] pressure_q24_8;
  logic [1:0]  status;

  comp_scoreboard board;
  int  cycles = 0;
  int  readings_sent = 0;
  bit  load_busy = 1'b0; // hold output stalls off while the block drains

  always #5 clk = ~clk;

  pressure_temp_compensation DUT (.*);

  // Gap length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Watchdog: abort on a stuck handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, board.pending.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check each transfer, then stall at random
  initial begin
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        board.check_result(temperature_centi, fine_temperature, pressure_q24_8, status);
      if (gap > 0) begin
        gap--;
        out_stall <= 1'b1;
      end else begin
        gap = load_busy ? 0 : pick_gap();
        out_stall <= (gap > 0);
      end
    end
  end

  // Write one coefficient register over APB: setup, access, then idle
  task automatic write_coeff(input logic [1:0] idx, input logic [47:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    board.coeff[idx] = val;
  endtask

  task automatic set_coeffs(input logic [47:0] t, input logic [47:0] a,
                            input logic [47:0] b, input logic [47:0] c);
    write_coeff(ptc_pkg::REG_TEMP, t);
    write_coeff(ptc_pkg::REG_PRESS_A, a);
    write_coeff(ptc_pkg::REG_PRESS_B, b);
    write_coeff(ptc_pkg::REG_PRESS_C, c);
  endtask

  // Offer one reading pair, hold it until the transfer happens, then idle if a gap is given
  task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp, input int gap);
    in_valid     <= 1'b1;
    temp_sample  <= rt;
    press_sample <= rp;
    do @(posedge clk); while (in_stall);
    board.note_reading(rt, rp);
    readings_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain: wait until every expected result is in, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    load_busy = 1'b1;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    load_busy = 1'b0;
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(0, 16'hffff)), $urandom()};
  endfunction

  // Typical sensor calibration with a little random spread
  function automatic logic [47:0] typ_temp();
    return {16'd50 + 16'($urandom_range(0, 20)), 16'd26435, 16'd27504};
  endfunction

  task automatic random_phase(input int n, input bit typical);
    for (int i = 0; i < n; i++) begin
      logic [19:0] rt, rp;
      int mode;
      mode = $urandom_range(0, 9);
      if (typical && mode < 7) begin
        rt = 20'd519888 + 20'($urandom_range(0, 60000)) - 20'd30000;
        rp = 20'd415148 + 20'($urandom_range(0, 200000)) - 20'd100000;
      end else if (mode == 9) begin
        rt = $urandom_range(0, 1) ? 20'hfffff : 20'd0;
        rp = $urandom_range(0, 1) ? 20'hfffff : 20'd0;
      end else begin
        rt = 20'($urandom());
        rp = 20'($urandom());
      end
      send_reading(rt, rp, ($urandom_range(0, 3) == 0) ? 0 : pick_gap());
    end
  endtask

  initial begin
    logic [47:0] typ_a, typ_b, typ_c;
    board = new();
    typ_a = {16'hf3ec, 16'hd6d0, 16'd36477}; // P3=-3092 P2=-10544 P1
    typ_b = {16'hfff9, 16'd140, 16'd2855};   // P6=-7, P5=140, P4
    typ_c = {16'd6000, 16'hc4fc, 16'd15500};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset coefficients: fine temperature zero on every item
    send_reading(20'd0, 20'd0, 0);
    send_reading(20'hfffff, 20'hfffff, 1);
    drain();

    // Typical calibration, field extremes
    set_coeffs(typ_temp(), typ_a, typ_b, typ_c);
    send_reading(20'd519888, 20'd415148, 0);
    send_reading(20'd0, 20'd0, 0);
    send_reading(20'hfffff, 20'hfffff, 0);
    send_reading(20'h55555, 20'haaaaa, 2);
    send_reading(20'haaaaa, 20'h55555, 0);
    send_reading(20'hfffff, 20'd0, 0);
    drain();

    // T2 = 0, T3 = 0: fine temperature zero regardless of reading
    set_coeffs({16'd0, 16'd0, 16'd1234}, typ_a, typ_b, typ_c);
    send_reading(20'd12345, 20'd54321, 0);
    send_reading(20'hfffff, 20'd1, 0);
    drain();

    // P1 = 0: divisor zero
    set_coeffs(typ_temp(), {typ_a[47:16], 16'd0}, typ_b, typ_c);
    send_reading(20'd519888, 20'd415148, 0);
    send_reading(20'd1, 20'hfffff, 0);
    drain();

    // All-ones and most negative coefficients: wrapping corners
    set_coeffs(48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff,
               48'hffff_ffff_ffff);
    send_reading(20'hfffff, 20'hfffff, 0);
    send_reading(20'd0, 20'd0, 0);
    send_reading(20'h80000, 20'h80000, 0);
    drain();
    set_coeffs(48'h8000_8000_ffff, 48'h8000_8000_ffff, 48'h8000_8000_8000,
               48'h8000_8000_8000);
    send_reading(20'hfffff, 20'd0, 0);
    send_reading(20'd0, 20'hfffff, 0);
    send_reading(20'h7ffff, 20'h12345, 0);
    drain();

    // Random part: realistic and fully random calibrations in turn
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0)
        set_coeffs(typ_temp(), typ_a ^ {32'd0, 16'($urandom_range(0, 255))},
                   typ_b, typ_c ^ {16'($urandom_range(0, 255)), 32'd0});
      else
        set_coeffs(rand48(), rand48(), rand48(), rand48());
      random_phase(100, ph % 2 == 0);
      drain();
    end

    $display("Covered %0d readings over several coefficient sets, %0d results checked",
             readings_sent, board.checked);
    $display("Status counts: ok %0d, fine temperature zero %0d, divisor zero %0d",
             board.st_seen[ptc_pkg::ST_OK], board.st_seen[ptc_pkg::ST_TF_ZERO],
             board.st_seen[ptc_pkg::ST_DIV_ZERO]);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
